// ===== rtl/abpd_pkg.sv =====
// ----------------------------------------------------------------------------
// abpd_pkg
// Shared types and constants of the ambient brightness PWM dimmer.
// ----------------------------------------------------------------------------
package abpd_pkg;

  // Field widths
  localparam int LEVEL_W = 10;
  localparam int MS_W    = 10;
  localparam int STEPS_W = 4;

  // Fixed figures of the dimming law
  localparam int LEVEL_MAX     = 1023;
  localparam int MS_PER_SECOND = 1000;
  localparam int MEAN_CLAMP    = 600;
  localparam int STEP_WIDTH    = 61;
  localparam int MAX_STEPS     = MEAN_CLAMP / STEP_WIDTH + 1;

  // Request kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] light_level;
    logic [MS_W-1:0]    ms_in_second;
  } abpd_in_t;

  typedef struct packed {
    logic               output_enable;
    logic [STEPS_W-1:0] dim_steps;
  } abpd_out_t;

endpackage

// ===== rtl/ambient_brightness_pwm_dimmer_unit.sv =====
// ----------------------------------------------------------------------------
// ambient_brightness_pwm_dimmer_unit
// Averages ambient light over a second and derives the display dimming
// divisor; refresh ticks run the PWM phase that gates output enable.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the output is not stalled, and
// each result passes the input register, slot lookup, sum update and result
// register in turn after acceptance. The rate is set by the single read-modify-write of the slot
// store in the sum stage, which a write-to-read bypass keeps at one per cycle.
// The slot store needs no clearing pass after reset: per-slot valid bits
// make unwritten slots read as zero. A stalled output holds the whole
// pipeline; while the result register is free or being taken, a new request
// is accepted in the same cycle.
module ambient_brightness_pwm_dimmer_unit
  import abpd_pkg::*;
#(
  parameter int SLOT_COUNT = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  abpd_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output abpd_out_t out_rsp_o
);

  // Slot selection: index = ms / SLOT_SPAN by exact reciprocal multiply
  localparam int SLOT_SPAN  = MS_PER_SECOND / SLOT_COUNT;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int IDX_SHIFT  = MS_W + $clog2(SLOT_SPAN);
  localparam longint IDX_MULT =
    ((longint'(1) << IDX_SHIFT) + longint'(SLOT_SPAN) - 1) / longint'(SLOT_SPAN);
  localparam int IDX_MULT_W = MS_W + 1;
  localparam int IDX_PROD_W = MS_W + IDX_MULT_W;
  localparam logic [IDX_MULT_W-1:0] IDX_MULT_C = IDX_MULT_W'(IDX_MULT);

  // Mean: sum / SLOT_COUNT by exact reciprocal multiply
  localparam int SUM_MAX     = SLOT_COUNT * LEVEL_MAX;
  localparam int SUM_W       = $clog2(SUM_MAX + 1);
  localparam int MEAN_SHIFT  = SUM_W + $clog2(SLOT_COUNT);
  localparam longint MEAN_MULT =
    ((longint'(1) << MEAN_SHIFT) + longint'(SLOT_COUNT) - 1) / longint'(SLOT_COUNT);
  localparam int MEAN_MULT_W = SUM_W + 1;
  localparam int MEAN_PROD_W = SUM_W + MEAN_MULT_W;
  localparam logic [MEAN_MULT_W-1:0] MEAN_MULT_C = MEAN_MULT_W'(MEAN_MULT);

  // Width of the phase arithmetic (quotient times divisor)
  localparam int PH_W = 2 * STEPS_W;

  // Pipeline control
  logic adv;

  // Stage 1: input register
  logic     v1_q;
  abpd_in_t req1_q;

  // Stage 1 logic: slot index
  logic [MS_W-1:0]       ms_red;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [MS_W-1:0]       idx_raw;
  logic [IDX_W-1:0]      idx1;

  // Stage 2: lookup results
  logic               v2_q;
  logic               kind2_q;
  logic [LEVEL_W-1:0] level2_q;
  logic [IDX_W-1:0]   idx2_q;
  logic [LEVEL_W-1:0] rdata_q;
  logic               rvalid_q;
  logic               fwd_q;
  logic [LEVEL_W-1:0] fwd_level_q;

  // Slot store with per-slot valid bits
  logic [LEVEL_W-1:0]    slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid_q;

  // Stage 2 logic: running sum
  logic               wr_en;
  logic [LEVEL_W-1:0] old_level;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   sum_d;

  // Stage 3: sum carried to the step logic
  logic             v3_q;
  logic             kind3_q;
  logic [SUM_W-1:0] sum3_q;

  // Stage 3 logic: steps and phase
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic [LEVEL_W-1:0]     mean;
  logic [LEVEL_W-1:0]     mean_c;
  logic [STEPS_W-1:0]     steps_new;
  logic [STEPS_W-1:0]     step_q;
  logic [STEPS_W-1:0]     phase_q;
  logic [STEPS_W-1:0]     phase_inc;
  logic [STEPS_W-1:0]     phase_d;
  logic [PH_W-1:0]        qd_prod;

  // Output register
  logic      out_valid_q;
  abpd_out_t out_q;

  // Move the whole pipeline unless a held result is stalled
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Capture accepted requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req1_q <= in_req_i;
    end
  end

  // Fold the millisecond into one second and pick its slot
  always_comb begin
    ms_red = (req1_q.ms_in_second >= MS_W'(MS_PER_SECOND))
             ? req1_q.ms_in_second - MS_W'(MS_PER_SECOND)
             : req1_q.ms_in_second;
    idx_prod = {{IDX_MULT_W{1'b0}}, ms_red} * {{MS_W{1'b0}}, IDX_MULT_C};
    idx_raw  = MS_W'(idx_prod >> IDX_SHIFT);
    idx1     = (idx_raw >= MS_W'(SLOT_COUNT)) ? IDX_W'(SLOT_COUNT - 1)
                                              : idx_raw[IDX_W-1:0];
  end

  // Write the slot when a sample leaves stage 2
  assign wr_en = adv && v2_q && (kind2_q == KIND_SAMPLE);

  // Slot store: registered read, single write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[idx2_q] <= level2_q;
    end
    if (adv) begin
      rdata_q <= slot_mem[idx1];
    end
  end

  // Mark slots written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (wr_en) begin
      slot_valid_q[idx2_q] <= 1'b1;
    end
  end

  // Advance stage 2 control and bypass flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else if (adv) begin
      v2_q  <= v1_q;
      fwd_q <= wr_en && (idx2_q == idx1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind2_q     <= req1_q.kind;
      level2_q    <= req1_q.light_level;
      idx2_q      <= idx1;
      rvalid_q    <= slot_valid_q[idx1];
      fwd_level_q <= level2_q;
    end
  end

  // Replace the old slot value in the running sum
  always_comb begin
    if (fwd_q) begin
      old_level = fwd_level_q;
    end else if (rvalid_q) begin
      old_level = rdata_q;
    end else begin
      old_level = '0;
    end
    sum_d = sum_q - SUM_W'(old_level) + SUM_W'(level2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      v3_q  <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
      if (wr_en) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind3_q <= kind2_q;
      sum3_q  <= sum_d;
    end
  end

  // Mean, clamp and step count
  always_comb begin
    mean_prod = {{MEAN_MULT_W{1'b0}}, sum3_q} * {{SUM_W{1'b0}}, MEAN_MULT_C};
    mean      = LEVEL_W'(mean_prod >> MEAN_SHIFT);
    mean_c    = (mean > LEVEL_W'(MEAN_CLAMP)) ? LEVEL_W'(MEAN_CLAMP) : mean;
    steps_new = STEPS_W'(1);
    for (int k = 1; k < MAX_STEPS; k++) begin
      if (mean_c >= LEVEL_W'(STEP_WIDTH * k)) begin
        steps_new = STEPS_W'(k + 1);
      end
    end
  end

  // Next phase: (phase + 1) mod step, by picking the largest multiple
  always_comb begin
    phase_inc = phase_q + STEPS_W'(1);
    phase_d   = phase_inc;
    qd_prod   = '0;
    for (int q = 1; q <= MAX_STEPS; q++) begin
      qd_prod = PH_W'(q) * {{(PH_W - STEPS_W){1'b0}}, step_q};
      if (qd_prod <= {{(PH_W - STEPS_W){1'b0}}, phase_inc}) begin
        phase_d = STEPS_W'({{(PH_W - STEPS_W){1'b0}}, phase_inc} - qd_prod);
      end
    end
  end

  // Update divisor or phase and hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEPS_W'(1);
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v3_q;
      if (v3_q) begin
        if (kind3_q == KIND_SAMPLE) begin
          step_q <= steps_new;
        end else begin
          phase_q <= phase_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      if (kind3_q == KIND_SAMPLE) begin
        out_q.output_enable <= 1'b0;
        out_q.dim_steps     <= steps_new;
      end else begin
        out_q.output_enable <= (phase_d == '0);
        out_q.dim_steps     <= step_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Divisor stays within its legal range
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q >= STEPS_W'(1)) && (step_q <= STEPS_W'(MAX_STEPS)))
    else $error("step divisor out of range");

  // Phase is always below the largest divisor
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < STEPS_W'(MAX_STEPS))
    else $error("PWM phase out of range");

  // Running sum never exceeds a full store
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_W'(SUM_MAX))
    else $error("running sum overflow");

  // A sample result never raises output enable
  a_sample_oe_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q && (kind3_q == KIND_SAMPLE)) |=> !out_rsp_o.output_enable)
    else $error("output enable set by a sample");

  // A held, stalled result blocks new requests
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("request accepted while result stalled");

endmodule
